/* hw/rtl/round_robin_thread_picker_macros.svh */
// Assertion macros for the round-robin thread picker.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef ROUND_ROBIN_THREAD_PICKER_MACROS_SVH
`define ROUND_ROBIN_THREAD_PICKER_MACROS_SVH

`ifndef SYNTH
`define RRTP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rrtp assertion failed");
`define RRTP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rrtp assertion failed");
`else
`define RRTP_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define RRTP_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* hw/rtl/rrtp_pkg.sv */
// Shared types and constants for the round-robin thread picker.
// No dependencies; used by both RTL modules of the block, rrtp_sec_floor and round_robin_thread_picker.
package rrtp_pkg;

  localparam int OP_W       = 2;
  localparam int SLOT_W     = 4;
  localparam int TIME_IN_W  = 32;
  localparam int STATUS_W   = 2;
  localparam int COUNT_W    = 5;

  localparam int DEF_SLOTS      = 16;
  localparam int DEF_TIME_WIDTH = 32;

  localparam int MS_PER_SECOND = 1000;
  localparam int REM_W         = $clog2(MS_PER_SECOND);

  localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_SET    = 2'd2;
  localparam logic [OP_W-1:0] OP_PICK   = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NONE = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]      op;
    logic [SLOT_W-1:0]    slot;
    logic                 ready_in;
    logic                 blocked_in;
    logic [TIME_IN_W-1:0] wake_in;
    logic                 join_valid_in;
    logic [SLOT_W-1:0]    join_slot_in;
    logic [TIME_IN_W-1:0] now_ms;
  } in_t;

  typedef struct packed {
    logic [SLOT_W-1:0]   result_slot;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  thread_count;
  } out_t;

endpackage

/* hw/rtl/rrtp_sec_floor.sv */
// Rounds a millisecond time down to a whole second by folding it modulo one second.
// Uses rrtp_pkg for the millisecond constant and the remainder width.
module rrtp_sec_floor #(
  parameter int TIME_WIDTH = rrtp_pkg::DEF_TIME_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [TIME_WIDTH-1:0] value,
  output logic                  done,
  output logic [TIME_WIDTH-1:0] floor_val
);

  localparam int RW = rrtp_pkg::REM_W;
  localparam int WW = (TIME_WIDTH > RW) ? TIME_WIDTH : RW + 1;
  localparam int HW = WW - RW;
  localparam logic [WW-1:0] FOLD_K = WW'((1 << RW) - rrtp_pkg::MS_PER_SECOND);
  localparam logic [RW-1:0] MS_K   = RW'(rrtp_pkg::MS_PER_SECOND);

  logic                  run_r, run_nxt;
  logic                  done_r, done_nxt;
  logic [WW-1:0]         acc_r, acc_nxt;
  logic [TIME_WIDTH-1:0] val_r, val_nxt;
  logic [TIME_WIDTH-1:0] floor_r, floor_nxt;
  logic [HW-1:0]         acc_hi;
  logic [WW-1:0]         fold;
  logic [RW-1:0]         rem;

  // 2**RW leaves FOLD_K modulo one second, so each fold keeps the remainder
  always_comb begin
    acc_hi = acc_r[WW-1:RW];
    fold   = WW'(acc_hi) * FOLD_K + WW'(acc_r[RW-1:0]);
    rem    = (acc_r[RW-1:0] >= MS_K) ? acc_r[RW-1:0] - MS_K : acc_r[RW-1:0];
  end

  always_comb begin
    run_nxt   = run_r;
    done_nxt  = 1'b0;
    acc_nxt   = acc_r;
    val_nxt   = val_r;
    floor_nxt = floor_r;
    if (start) begin
      run_nxt = 1'b1;
      acc_nxt = WW'(value);
      val_nxt = value;
    end else if (run_r) begin
      if (acc_hi != '0) begin
        acc_nxt = fold;
      end else begin
        run_nxt   = 1'b0;
        done_nxt  = 1'b1;
        floor_nxt = val_r - TIME_WIDTH'(rem);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
    acc_r   <= acc_nxt;
    val_r   <= val_nxt;
    floor_r <= floor_nxt;
  end

  assign done      = done_r;
  assign floor_val = floor_r;

endmodule

/* hw/rtl/round_robin_thread_picker.sv */
// Round-robin thread picker: ring of thread slots with add, remove, set status and pick.
// Depends on rrtp_pkg, rrtp_sec_floor and round_robin_thread_picker_macros.svh.
//
// One command is taken when start is high and busy is low; busy stays high until the
// command's single result has been issued, and the result appears on out_data for exactly
// one cycle with out_valid high. The receiver cannot stall, so results must be captured on
// that cycle. Every command passes through the decode state first. Set status and any
// rejected command finish there. Remove then goes through a link-update state. Add scans
// the in-use flags one slot per cycle from slot 0; unless the ring was empty, it then links
// the new slot in at the tail through the states S_ADD_LINK and S_ADD_LINK2. Pick first
// rounds the current time down to a whole second in the fold unit rrtp_sec_floor, which
// folds the bits above the low ten back into them once per cycle (a 32-bit time needs at
// most six folds) and then does the final compare; Pick then walks the ring one slot per
// cycle through the link memories.
`include "round_robin_thread_picker_macros.svh"

module round_robin_thread_picker #(
  parameter int SLOTS      = rrtp_pkg::DEF_SLOTS,
  parameter int TIME_WIDTH = rrtp_pkg::DEF_TIME_WIDTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  rrtp_pkg::in_t  in_data,
  output logic           out_valid,
  output rrtp_pkg::out_t out_data
);

  localparam int IW  = $clog2(SLOTS);
  localparam int CW  = $clog2(SLOTS + 1);
  localparam int SW  = rrtp_pkg::SLOT_W;
  localparam int OCW = rrtp_pkg::COUNT_W;
  localparam int TW  = TIME_WIDTH;

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_DECODE    = 3'd1;
  localparam logic [2:0] S_ADD_SCAN  = 3'd2;
  localparam logic [2:0] S_ADD_LINK  = 3'd3;
  localparam logic [2:0] S_ADD_LINK2 = 3'd4;
  localparam logic [2:0] S_REM_LINK  = 3'd5;
  localparam logic [2:0] S_PICK_DIV  = 3'd6;
  localparam logic [2:0] S_PICK_WALK = 3'd7;

  logic [2:0]      state_r, state_nxt;
  rrtp_pkg::in_t   in_r;
  logic [SLOTS-1:0] in_use_r, in_use_nxt;
  logic [SLOTS-1:0] ready_r, ready_nxt;
  logic [SLOTS-1:0] blocked_r, blocked_nxt;
  logic [SLOTS-1:0] jvalid_r, jvalid_nxt;
  logic [IW-1:0]   head_r, head_nxt;
  logic [CW-1:0]   live_r, live_nxt;
  logic [IW-1:0]   scan_r, scan_nxt;
  logic [IW-1:0]   cur_r, cur_nxt;
  logic [CW-1:0]   steps_r, steps_nxt;
  logic            use_next_r, use_next_nxt;

  logic            out_valid_r, out_valid_nxt;
  logic [SW-1:0]   out_slot_r, out_slot_nxt;
  logic [rrtp_pkg::STATUS_W-1:0] out_status_r, out_status_nxt;

  logic [IW-1:0]   nx_mem [SLOTS];
  logic [IW-1:0]   pv_mem [SLOTS];
  logic [TW-1:0]   wk_mem [SLOTS];
  logic [SW-1:0]   jn_mem [SLOTS];
  logic [IW-1:0]   nx_q, pv_q;
  logic [TW-1:0]   wk_q;
  logic [SW-1:0]   jn_q;
  logic [IW-1:0]   rd_addr;

  logic            nx_we, pv_we, wk_we, jn_we;
  logic [IW-1:0]   nx_wa, nx_wd, pv_wa, pv_wd, wk_wa, jn_wa;
  logic [TW-1:0]   wk_wd;
  logic [SW-1:0]   jn_wd;

  logic            fl_start, fl_done;
  logic [TW-1:0]   fl_floor;

  logic [IW-1:0]   s_idx;
  logic            s_in_range, s_live;
  logic [IW-1:0]   j_idx;
  logic            j_live, eligible;
  logic [IW-1:0]   pick_first;

  rrtp_sec_floor #(
    .TIME_WIDTH(TIME_WIDTH)
  ) u_sec_floor (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (fl_start),
    .value    (TW'(in_r.now_ms)),
    .done     (fl_done),
    .floor_val(fl_floor)
  );

  always_comb begin
    s_idx      = IW'(in_r.slot);
    s_in_range = int'(in_r.slot) < SLOTS;
    s_live     = s_in_range && in_use_r[s_idx];
    j_idx      = IW'(jn_q);
    j_live     = (int'(jn_q) < SLOTS) && in_use_r[j_idx];
    eligible   = ready_r[cur_r] && !blocked_r[cur_r] && (wk_q <= fl_floor) &&
                 !(jvalid_r[cur_r] && j_live && ready_r[j_idx]);
    pick_first = use_next_r ? nx_q : head_r;
  end

  always_comb begin
    state_nxt      = state_r;
    in_use_nxt     = in_use_r;
    ready_nxt      = ready_r;
    blocked_nxt    = blocked_r;
    jvalid_nxt     = jvalid_r;
    head_nxt       = head_r;
    live_nxt       = live_r;
    scan_nxt       = scan_r;
    cur_nxt        = cur_r;
    steps_nxt      = steps_r;
    use_next_nxt   = use_next_r;
    out_valid_nxt  = 1'b0;
    out_slot_nxt   = '0;
    out_status_nxt = rrtp_pkg::ST_OK;
    rd_addr        = s_idx;
    fl_start       = 1'b0;
    nx_we = 1'b0; nx_wa = '0; nx_wd = '0;
    pv_we = 1'b0; pv_wa = '0; pv_wd = '0;
    wk_we = 1'b0; wk_wa = '0; wk_wd = '0;
    jn_we = 1'b0; jn_wa = '0; jn_wd = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (in_r.op)
          rrtp_pkg::OP_ADD: begin
            if (live_r == CW'(SLOTS)) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = rrtp_pkg::ST_FULL;
              state_nxt      = S_IDLE;
            end else begin
              scan_nxt  = '0;
              state_nxt = S_ADD_SCAN;
            end
          end
          rrtp_pkg::OP_REMOVE: begin
            if (!s_live) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = rrtp_pkg::ST_NONE;
              state_nxt      = S_IDLE;
            end else begin
              state_nxt = S_REM_LINK;
            end
          end
          rrtp_pkg::OP_SET: begin
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
            if (!s_in_range) begin
              out_status_nxt = rrtp_pkg::ST_NONE;
            end else begin
              ready_nxt[s_idx]   = in_r.ready_in;
              blocked_nxt[s_idx] = in_r.blocked_in;
              jvalid_nxt[s_idx]  = in_r.join_valid_in;
              wk_we = 1'b1; wk_wa = s_idx; wk_wd = TW'(in_r.wake_in);
              jn_we = 1'b1; jn_wa = s_idx; jn_wd = in_r.join_slot_in;
            end
          end
          rrtp_pkg::OP_PICK: begin
            if (live_r == '0) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = rrtp_pkg::ST_NONE;
              state_nxt      = S_IDLE;
            end else begin
              use_next_nxt = s_live && ready_r[s_idx];
              fl_start     = 1'b1;
              state_nxt    = S_PICK_DIV;
            end
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_ADD_SCAN: begin
        if (!in_use_r[scan_r]) begin
          in_use_nxt[scan_r]  = 1'b1;
          ready_nxt[scan_r]   = 1'b1;
          blocked_nxt[scan_r] = 1'b0;
          jvalid_nxt[scan_r]  = 1'b0;
          wk_we = 1'b1; wk_wa = scan_r; wk_wd = '0;
          if (live_r == '0) begin
            nx_we = 1'b1; nx_wa = scan_r; nx_wd = scan_r;
            pv_we = 1'b1; pv_wa = scan_r; pv_wd = scan_r;
            head_nxt      = scan_r;
            live_nxt      = live_r + 1'b1;
            out_valid_nxt = 1'b1;
            out_slot_nxt  = SW'(scan_r);
            state_nxt     = S_IDLE;
          end else begin
            rd_addr   = head_r;
            state_nxt = S_ADD_LINK;
          end
        end else begin
          scan_nxt = scan_r + 1'b1;
        end
      end
      S_ADD_LINK: begin
        pv_we = 1'b1; pv_wa = scan_r; pv_wd = pv_q;
        nx_we = 1'b1; nx_wa = pv_q;   nx_wd = scan_r;
        state_nxt = S_ADD_LINK2;
      end
      S_ADD_LINK2: begin
        nx_we = 1'b1; nx_wa = scan_r; nx_wd = head_r;
        pv_we = 1'b1; pv_wa = head_r; pv_wd = scan_r;
        live_nxt      = live_r + 1'b1;
        out_valid_nxt = 1'b1;
        out_slot_nxt  = SW'(scan_r);
        state_nxt     = S_IDLE;
      end
      S_REM_LINK: begin
        nx_we = 1'b1; nx_wa = pv_q; nx_wd = nx_q;
        pv_we = 1'b1; pv_wa = nx_q; pv_wd = pv_q;
        in_use_nxt[s_idx] = 1'b0;
        ready_nxt[s_idx]  = 1'b0;
        live_nxt          = live_r - 1'b1;
        if (live_r == CW'(1)) begin
          head_nxt = '0;
        end else if (head_r == s_idx) begin
          head_nxt = nx_q;
        end
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_PICK_DIV: begin
        if (fl_done) begin
          rd_addr   = pick_first;
          cur_nxt   = pick_first;
          steps_nxt = '0;
          state_nxt = S_PICK_WALK;
        end
      end
      S_PICK_WALK: begin
        if (eligible) begin
          out_valid_nxt = 1'b1;
          out_slot_nxt  = SW'(cur_r);
          state_nxt     = S_IDLE;
        end else if (steps_r + 1'b1 == live_r) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = rrtp_pkg::ST_NONE;
          state_nxt      = S_IDLE;
        end else begin
          rd_addr   = nx_q;
          cur_nxt   = nx_q;
          steps_nxt = steps_r + 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (nx_we) begin
      nx_mem[nx_wa] <= nx_wd;
    end
    if (pv_we) begin
      pv_mem[pv_wa] <= pv_wd;
    end
    if (wk_we) begin
      wk_mem[wk_wa] <= wk_wd;
    end
    if (jn_we) begin
      jn_mem[jn_wa] <= jn_wd;
    end
    nx_q <= nx_mem[rd_addr];
    pv_q <= pv_mem[rd_addr];
    wk_q <= wk_mem[rd_addr];
    jn_q <= jn_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_use_r    <= '0;
      ready_r     <= '0;
      blocked_r   <= '0;
      jvalid_r    <= '0;
      head_r      <= '0;
      live_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_use_r    <= in_use_nxt;
      ready_r     <= ready_nxt;
      blocked_r   <= blocked_nxt;
      jvalid_r    <= jvalid_nxt;
      head_r      <= head_nxt;
      live_r      <= live_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (start && !busy) begin
      in_r <= in_data;
    end
    scan_r       <= scan_nxt;
    cur_r        <= cur_nxt;
    steps_r      <= steps_nxt;
    use_next_r   <= use_next_nxt;
    out_slot_r   <= out_slot_nxt;
    out_status_r <= out_status_nxt;
  end

  assign busy                  = state_r != S_IDLE;
  assign out_valid             = out_valid_r;
  assign out_data.result_slot  = out_slot_r;
  assign out_data.status       = out_status_r;
  assign out_data.thread_count = OCW'(live_r);

  `RRTP_ASSERT_NXT(a_accept_decodes, clk, rst_n, start && !busy, state_r == S_DECODE)
  `RRTP_ASSERT_IMP(a_count_matches_flags, clk, rst_n, state_r == S_IDLE, $countones(in_use_r) == int'(live_r))
  `RRTP_ASSERT_IMP(a_count_in_range, clk, rst_n, 1'b1, int'(live_r) <= SLOTS)
  `RRTP_ASSERT_IMP(a_walk_bounded, clk, rst_n, state_r == S_PICK_WALK, steps_r < live_r)
  `RRTP_ASSERT_IMP(a_floor_only_in_pick, clk, rst_n, fl_done, state_r == S_PICK_DIV)

endmodule
